[rtl/nbr_pkg.sv]
// nbr_pkg: shared types and constants of the nal payload bit reader
// used by the controller, the datapath, the top level and the port checker
// depends on nothing
`default_nettype none

package nbr_pkg;

  // command codes on the request channel
  typedef enum logic [2:0] {
    MODE_RESTART = 3'd0,
    MODE_LOAD    = 3'd1,
    MODE_READ    = 3'd2,
    MODE_SKIP    = 3'd3,
    MODE_UE      = 3'd4,
    MODE_SE      = 3'd5,
    MODE_SCALING = 3'd6
  } mode_t;

  // fixed constants of the bitstream syntax
  localparam logic [7:0]  EP_BYTE    = 8'h03;
  localparam logic [7:0]  SL_START   = 8'd8;
  localparam int unsigned MAX_READ   = 32;
  localparam int unsigned SKIP_CHUNK = 16;
  localparam int unsigned BYTE_BITS  = 8;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_BIT,
    S_FILL,
    S_INSP,
    S_EPRD,
    S_RET,
    S_SKIP,
    S_UE_END,
    S_SL,
    S_RESULT
  } ctrl_state_t;

  // what a finished field read feeds into
  typedef enum logic [1:0] {
    PH_READ,
    PH_SKIP,
    PH_PREFIX,
    PH_SUFFIX
  } phase_t;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_RESTART,
    OP_LOAD,
    OP_SHIFT,
    OP_FILL,
    OP_INSP,
    OP_EP_SKIP,
    OP_EP_ZR,
    OP_COMMIT,
    OP_SKIP_ADV,
    OP_ZERO_INC,
    OP_UE_ZERO,
    OP_UE_SUFFIX,
    OP_SE_MAP,
    OP_SL_STEP,
    OP_RESULT
  } dp_op_t;

  // field size source for a new field read
  typedef enum logic [1:0] {
    SZ_COUNT,
    SZ_ONE,
    SZ_ZEROS,
    SZ_CHUNK
  } size_sel_t;

  // kind of result written to the output register
  typedef enum logic [1:0] {
    RES_OK,
    RES_FAIL,
    RES_ACC,
    RES_CODE
  } res_kind_t;

  typedef struct packed {
    dp_op_t    op;
    logic      gb_start;
    size_sel_t size_sel;
    logic      zeros_clr;
    res_kind_t res_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       count_gt32;
    logic       count_zero;
    logic       full;
    logic       gb_end;
    logic       need_insp;
    logic       idx_ok;
    logic       cache_hit;
    logic       ep;
    logic       ep_ok;
    logic       bit_one;
    logic       zeros_zero;
    logic       zeros_last;
    logic       skip_left;
    logic       sl_more;
    logic       res_free;
  } dp_stat_t;

endpackage

`default_nettype wire

[rtl/nbr_ctrl.sv]
// nbr_ctrl: state machine that sequences restart, load, field reads,
// exp-golomb decoding and scaling list skipping over the datapath
// depends on nbr_pkg
`default_nettype none

module nbr_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_stall,
  input  nbr_pkg::dp_stat_t stat,
  output nbr_pkg::dp_cmd_t  cmd
);
  import nbr_pkg::*;

  ctrl_state_t state, state_next;
  phase_t      phase, phase_next;
  res_kind_t   res_kind, res_kind_next;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      phase    <= PH_READ;
      res_kind <= RES_FAIL;
    end else begin
      state    <= state_next;
      phase    <= phase_next;
      res_kind <= res_kind_next;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_next    = state;
    phase_next    = phase;
    res_kind_next = res_kind;
    in_stall      = 1'b1;
    cmd.op        = OP_NONE;
    cmd.gb_start  = 1'b0;
    cmd.size_sel  = SZ_ONE;
    cmd.zeros_clr = 1'b0;
    cmd.res_kind  = res_kind;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op     = OP_LATCH;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.mode)
          MODE_RESTART: begin
            cmd.op        = OP_RESTART;
            res_kind_next = RES_OK;
            state_next    = S_RESULT;
          end
          MODE_LOAD: begin
            if (stat.full) begin
              res_kind_next = RES_FAIL;
            end else begin
              cmd.op        = OP_LOAD;
              res_kind_next = RES_OK;
            end
            state_next = S_RESULT;
          end
          MODE_READ: begin
            if (stat.count_gt32) begin
              res_kind_next = RES_FAIL;
              state_next    = S_RESULT;
            end else begin
              cmd.gb_start = 1'b1;
              cmd.size_sel = SZ_COUNT;
              phase_next   = PH_READ;
              state_next   = S_BIT;
            end
          end
          MODE_SKIP: begin
            state_next = S_SKIP;
          end
          MODE_UE, MODE_SE, MODE_SCALING: begin
            if ((stat.mode == MODE_SCALING) && stat.count_zero) begin
              res_kind_next = RES_OK;
              state_next    = S_RESULT;
            end else begin
              cmd.gb_start  = 1'b1;
              cmd.size_sel  = SZ_ONE;
              cmd.zeros_clr = 1'b1;
              phase_next    = PH_PREFIX;
              state_next    = S_BIT;
            end
          end
          default: begin
            res_kind_next = RES_FAIL;
            state_next    = S_RESULT;
          end
        endcase
      end
      // one bit of the current field per cycle when the byte is cached and already inspected
      S_BIT: begin
        if (stat.gb_end) begin
          cmd.op     = OP_COMMIT;
          state_next = S_RET;
        end else if (!stat.idx_ok) begin
          res_kind_next = RES_FAIL;
          state_next    = S_RESULT;
        end else if (stat.need_insp) begin
          state_next = S_INSP;
        end else if (stat.cache_hit) begin
          cmd.op = OP_SHIFT;
        end else begin
          state_next = S_FILL;
        end
      end
      S_FILL: begin
        cmd.op     = OP_FILL;
        state_next = S_BIT;
      end
      // byte boundary: zero run tracking and emulation prevention
      S_INSP: begin
        if (stat.ep) begin
          if (stat.ep_ok) begin
            cmd.op     = OP_EP_SKIP;
            state_next = S_EPRD;
          end else begin
            res_kind_next = RES_FAIL;
            state_next    = S_RESULT;
          end
        end else begin
          cmd.op     = OP_INSP;
          state_next = S_BIT;
        end
      end
      S_EPRD: begin
        cmd.op     = OP_EP_ZR;
        state_next = S_BIT;
      end
      // a field read finished
      S_RET: begin
        case (phase)
          PH_READ: begin
            res_kind_next = RES_ACC;
            state_next    = S_RESULT;
          end
          PH_SKIP: begin
            cmd.op     = OP_SKIP_ADV;
            state_next = S_SKIP;
          end
          PH_PREFIX: begin
            if (stat.bit_one) begin
              if (stat.zeros_zero) begin
                cmd.op     = OP_UE_ZERO;
                state_next = S_UE_END;
              end else begin
                cmd.gb_start = 1'b1;
                cmd.size_sel = SZ_ZEROS;
                phase_next   = PH_SUFFIX;
                state_next   = S_BIT;
              end
            end else if (stat.zeros_last) begin
              res_kind_next = RES_FAIL;
              state_next    = S_RESULT;
            end else begin
              cmd.op       = OP_ZERO_INC;
              cmd.gb_start = 1'b1;
              cmd.size_sel = SZ_ONE;
              state_next   = S_BIT;
            end
          end
          PH_SUFFIX: begin
            cmd.op     = OP_UE_SUFFIX;
            state_next = S_UE_END;
          end
          default: begin
            res_kind_next = RES_FAIL;
            state_next    = S_RESULT;
          end
        endcase
      end
      S_UE_END: begin
        case (stat.mode)
          MODE_UE: begin
            res_kind_next = RES_CODE;
            state_next    = S_RESULT;
          end
          MODE_SE: begin
            cmd.op        = OP_SE_MAP;
            res_kind_next = RES_CODE;
            state_next    = S_RESULT;
          end
          default: begin
            cmd.op     = OP_SE_MAP;
            state_next = S_SL;
          end
        endcase
      end
      // scaling list entry done, start the next delta if needed
      S_SL: begin
        cmd.op = OP_SL_STEP;
        if (stat.sl_more) begin
          cmd.gb_start  = 1'b1;
          cmd.size_sel  = SZ_ONE;
          cmd.zeros_clr = 1'b1;
          phase_next    = PH_PREFIX;
          state_next    = S_BIT;
        end else begin
          res_kind_next = RES_OK;
          state_next    = S_RESULT;
        end
      end
      // skip in chunks of up to sixteen bits
      S_SKIP: begin
        if (stat.skip_left) begin
          cmd.gb_start = 1'b1;
          cmd.size_sel = SZ_CHUNK;
          phase_next   = PH_SKIP;
          state_next   = S_BIT;
        end else begin
          res_kind_next = RES_OK;
          state_next    = S_RESULT;
        end
      end
      S_RESULT: begin
        if (stat.res_free) begin
          cmd.op     = OP_RESULT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/nbr_dp.sv]
// nbr_dp: byte store, bit position, zero run, field accumulator, exp-golomb
// arithmetic and the output register of the nal payload bit reader
// depends on nbr_pkg
`default_nettype none

module nbr_dp #(
  parameter int MAX_BYTES = 256
) (
  input  wire               clk,
  input  wire               rst,
  input  nbr_pkg::dp_cmd_t  cmd,
  output nbr_pkg::dp_stat_t stat,
  input  wire  [2:0]        mode,
  input  wire  [7:0]        byte_in,
  input  wire  [11:0]       count,
  output logic              out_valid,
  input  wire               out_stall,
  output logic [31:0]       value,
  output logic              ok
);
  import nbr_pkg::*;

  localparam int AW    = $clog2(MAX_BYTES);
  localparam int CNT_W = $clog2(MAX_BYTES + 1);
  localparam int POS_W = AW + 4;
  localparam int IDX_W = POS_W - 3;

  // byte store
  logic [7:0]       mem [MAX_BYTES];
  logic [7:0]       rd_data;
  logic [AW-1:0]    rd_addr;

  // request latch
  logic [2:0]       mode_q;
  logic [7:0]       byte_in_q;
  logic [11:0]      count_q;

  // reader state
  logic [CNT_W-1:0] byte_count;
  logic [POS_W-1:0] bit_position;
  logic [1:0]       zero_run;

  // current field read
  logic [5:0]       off;
  logic [5:0]       size;
  logic [31:0]      acc;
  logic             insp;

  // one byte cache in front of the store
  logic [7:0]       cache;
  logic [IDX_W-1:0] tag;
  logic             cache_vld;

  // command loop registers
  logic [4:0]       zeros;
  logic [11:0]      done;
  logic [11:0]      j;
  logic [7:0]       last;
  logic [31:0]      code;

  // derived values
  logic [POS_W-1:0] pos;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_p1;
  logic [IDX_W-1:0] count_ext;
  logic             cur_bit;
  logic [11:0]      rem;
  logic [5:0]       chunk;
  logic [5:0]       size_mux;
  logic [31:0]      ue_val;
  logic [31:0]      se_val;
  logic [7:0]       nxt;
  logic [1:0]       zr_inc;

  assign pos       = bit_position + POS_W'(off);
  assign idx       = pos[POS_W-1:3];
  assign idx_p1    = idx + IDX_W'(1);
  assign count_ext = IDX_W'(byte_count);
  assign cur_bit   = cache[~pos[2:0]];
  assign rem       = count_q - done;
  assign chunk     = (rem >= 12'(SKIP_CHUNK)) ? 6'(SKIP_CHUNK) : 6'(rem);
  assign ue_val    = ~(32'hFFFF_FFFF << zeros) + acc;
  assign se_val    = code[0] ? ({1'b0, code[31:1]} + 32'd1) : (32'd0 - {1'b0, code[31:1]});
  assign nxt       = last + code[7:0];
  assign zr_inc    = (zero_run == 2'd3) ? 2'd3 : zero_run + 2'd1;
  assign rd_addr   = (cmd.op == OP_EP_SKIP) ? idx_p1[AW-1:0] : idx[AW-1:0];

  // size of a new field read
  always_comb begin
    case (cmd.size_sel)
      SZ_COUNT: size_mux = count_q[5:0];
      SZ_ONE:   size_mux = 6'd1;
      SZ_ZEROS: size_mux = {1'b0, zeros};
      SZ_CHUNK: size_mux = chunk;
      default:  size_mux = 6'd1;
    endcase
  end

  // status to the controller
  always_comb begin
    stat.mode       = mode_q;
    stat.count_gt32 = count_q > 12'(MAX_READ);
    stat.count_zero = count_q == 12'd0;
    stat.full       = byte_count == CNT_W'(MAX_BYTES);
    stat.gb_end     = off == size;
    stat.need_insp  = (pos[2:0] == 3'd0) && !insp;
    stat.idx_ok     = idx < count_ext;
    stat.cache_hit  = cache_vld && (tag == idx);
    stat.ep         = (rd_data == EP_BYTE) && (zero_run == 2'd2);
    stat.ep_ok      = idx_p1 < count_ext;
    stat.bit_one    = acc[0];
    stat.zeros_zero = zeros == 5'd0;
    stat.zeros_last = zeros == 5'(MAX_READ - 1);
    stat.skip_left  = done < count_q;
    stat.sl_more    = (({1'b0, j} + 13'd1) < {1'b0, count_q}) && (nxt != 8'd0);
    stat.res_free   = !out_valid || !out_stall;
  end

  // store write and registered read
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      mem[byte_count[AW-1:0]] <= byte_in_q;
    end
    rd_data <= mem[rd_addr];
  end

  // control registers of the reader
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      bit_position <= '0;
      zero_run     <= 2'd0;
      cache_vld    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      // a new result enters or the waiting one leaves
      if (cmd.op == OP_RESULT) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        OP_RESTART: begin
          byte_count   <= '0;
          bit_position <= '0;
          zero_run     <= 2'd0;
          cache_vld    <= 1'b0;
        end
        OP_LOAD:     byte_count <= byte_count + CNT_W'(1);
        OP_FILL:     cache_vld <= 1'b1;
        OP_INSP: begin
          cache_vld <= 1'b1;
          if (rd_data == 8'd0) begin
            zero_run <= zr_inc;
          end else begin
            zero_run <= 2'd0;
          end
        end
        OP_EP_SKIP:  bit_position <= bit_position + POS_W'(BYTE_BITS);
        OP_EP_ZR: begin
          cache_vld <= 1'b1;
          zero_run  <= (rd_data == 8'd0) ? 2'd1 : 2'd0;
        end
        OP_COMMIT:   bit_position <= bit_position + POS_W'(size);
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.gb_start) begin
      size <= size_mux;
      off  <= 6'd0;
      acc  <= 32'd0;
      insp <= 1'b0;
    end
    if (cmd.zeros_clr) begin
      zeros <= 5'd0;
    end
    case (cmd.op)
      OP_LATCH: begin
        mode_q    <= mode;
        byte_in_q <= byte_in;
        count_q   <= count;
        done      <= 12'd0;
        j         <= 12'd0;
        last      <= SL_START;
      end
      OP_SHIFT: begin
        acc  <= {acc[30:0], cur_bit};
        off  <= off + 6'd1;
        insp <= 1'b0;
      end
      OP_FILL: begin
        cache <= rd_data;
        tag   <= idx;
      end
      OP_INSP, OP_EP_ZR: begin
        cache <= rd_data;
        tag   <= idx;
        insp  <= 1'b1;
      end
      OP_SKIP_ADV:  done <= done + 12'(size);
      OP_ZERO_INC:  zeros <= zeros + 5'd1;
      OP_UE_ZERO:   code <= 32'd0;
      OP_UE_SUFFIX: code <= ue_val;
      OP_SE_MAP:    code <= se_val;
      OP_SL_STEP: begin
        j <= j + 12'd1;
        if (nxt != 8'd0) begin
          last <= nxt;
        end
      end
      OP_RESULT: begin
        case (cmd.res_kind)
          RES_OK: begin
            value <= 32'd0;
            ok    <= 1'b1;
          end
          RES_ACC: begin
            value <= acc;
            ok    <= 1'b1;
          end
          RES_CODE: begin
            value <= code;
            ok    <= 1'b1;
          end
          default: begin
            value <= 32'd0;
            ok    <= 1'b0;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/nal_bit_reader_exp_golomb.sv]
// nal_bit_reader_exp_golomb: top level of the nal payload bit reader
// instantiates nbr_ctrl and nbr_dp, depends on nbr_pkg
`default_nettype none

// Bit reader for an H.264 NAL payload with Exp-Golomb decoding. Bytes are
// appended with load requests into a store of MAX_BYTES entries and read MSB
// first; a 0x03 after exactly two zero bytes is dropped at byte boundaries.
// Each request (restart, load, read up to 32 bits, skip, ue, se, scaling list
// skip) returns one result with a value and an ok flag. One request is worked
// on at a time; the result sits in an output register, so the next request is
// taken while the previous result waits. A field read fetches every new byte
// from the single read port of the store. An Exp-Golomb code with n prefix
// zeros is read as n+1 one-bit field reads for the prefix and one field read
// of n bits. The store needs no clearing after reset.
module nal_bit_reader_exp_golomb #(
  parameter int MAX_BYTES = 256
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [2:0]  mode,
  input  wire  [7:0]  byte_in,
  input  wire  [11:0] count,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [31:0] value,
  output logic        ok
);
  import nbr_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  nbr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  nbr_dp #(
    .MAX_BYTES (MAX_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .mode      (mode),
    .byte_in   (byte_in),
    .count     (count),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .ok        (ok)
  );

endmodule

`default_nettype wire

[rtl/nbr_checker.sv]
// nbr_checker: port level assertions of the nal payload bit reader
// bound to nal_bit_reader_exp_golomb, depends on nbr_pkg
`default_nettype none

module nbr_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_stall,
  input wire [2:0]  mode,
  input wire        out_valid,
  input wire        out_stall,
  input wire [31:0] value,
  input wire        ok
);
  import nbr_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(value) && $stable(ok))
    else $error("stalled result changed");

  // one request at a time: stall follows every accepted request
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while another is in work");

  // a failed request always reports a zero value
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> value == 32'd0)
    else $error("failed result with nonzero value");

  // restart succeeds when the output is free
  a_restart: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_valid && (mode == MODE_RESTART)
    |=> ##2 out_valid && ok && (value == 32'd0))
    else $error("restart result missing or wrong");

  // an unknown request fails when the output is free
  a_bad_mode: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_valid && (mode > MODE_SCALING)
    |=> ##2 out_valid && !ok)
    else $error("unknown request did not fail");

endmodule

bind nal_bit_reader_exp_golomb nbr_checker u_nbr_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .mode      (mode),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .value     (value),
  .ok        (ok)
);

`default_nettype wire

[tb/sv/tb_nbr_pkg.sv]
// tb_nbr_pkg: request and result types plus the scoreboard of the nal payload bit reader bench
// the scoreboard keeps its own copy of the store and read position to predict each result
// depends on nbr_pkg
package tb_nbr_pkg;
  import nbr_pkg::*;

  // mode 7 has no member in the rtl enum, the block must reject it
  localparam logic [2:0]  MODE_INVALID = 3'd7;
  localparam int unsigned STORE_DEPTH  = 256;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  byte_in;
    logic [11:0] count;
  } request_t;

  typedef struct packed {
    logic [31:0] value;
    logic        ok;
  } result_t;

  class nal_reader_scoreboard;
    logic [7:0]  payload_mem [STORE_DEPTH];
    int unsigned byte_cnt;
    int unsigned bit_pos;
    int unsigned zero_run;
    result_t     awaited_results [$];
    int unsigned errors;

    function new();
      byte_cnt = 0;
      bit_pos  = 0;
      zero_run = 0;
      errors   = 0;
    endfunction

    // msb-first field read with emulation-prevention drop at byte boundaries
    function bit fetch_bits(int unsigned size, output logic [31:0] bits_out);
      logic [31:0] acc;
      int unsigned i;
      int unsigned pos;
      int unsigned idx;
      logic [7:0]  b;
      acc = '0;
      bits_out = '0;
      if (size > MAX_READ) return 1'b0;
      for (i = 0; i < size; i++) begin
        pos = bit_pos + i;
        if ((pos & 32'd7) == 0) begin
          idx = pos >> 3;
          if (idx >= byte_cnt) return 1'b0;
          b = payload_mem[idx];
          if (b == 8'h00) begin
            if (zero_run < 3) zero_run++;
          end else if (b == EP_BYTE && zero_run == 2) begin
            idx++;
            if (idx >= byte_cnt) return 1'b0;
            bit_pos += BYTE_BITS;
            zero_run = (payload_mem[idx] == 8'h00) ? 1 : 0;
          end else begin
            zero_run = 0;
          end
        end
        pos = bit_pos + i;
        idx = pos >> 3;
        if (idx >= byte_cnt) return 1'b0;
        acc[size - 1 - i] = payload_mem[idx][7 - (pos & 32'd7)];
      end
      bit_pos += size;
      bits_out = acc;
      return 1'b1;
    endfunction

    // unsigned exp-golomb, a prefix of 32 zeros fails
    function bit decode_ue(output logic [31:0] code);
      int unsigned zeros;
      logic [31:0] b;
      logic [31:0] suffix;
      code = '0;
      zeros = 0;
      while (1'b1) begin
        if (!fetch_bits(1, b)) return 1'b0;
        if (b != 0) break;
        zeros++;
        if (zeros >= MAX_READ) return 1'b0;
      end
      if (zeros != 0) begin
        if (!fetch_bits(zeros, suffix)) return 1'b0;
        code = (32'd1 << zeros) - 32'd1 + suffix;
      end
      return 1'b1;
    endfunction

    // signed exp-golomb: odd codes positive, even codes zero or negative
    function bit decode_se(output logic [31:0] code);
      logic [31:0] k;
      code = '0;
      if (!decode_ue(k)) return 1'b0;
      code = k[0] ? (k >> 1) + 32'd1 : 32'd0 - (k >> 1);
      return 1'b1;
    endfunction

    function result_t execute_command(request_t r);
      result_t     res;
      logic [31:0] v;
      int unsigned done;
      int unsigned n;
      int unsigned j;
      logic [7:0]  last;
      logic [7:0]  next_scale;
      res.value = '0;
      res.ok = 1'b0;
      case (r.mode)
        MODE_RESTART: begin
          byte_cnt = 0;
          bit_pos = 0;
          zero_run = 0;
          res.ok = 1'b1;
        end
        MODE_LOAD: begin
          if (byte_cnt < STORE_DEPTH) begin
            payload_mem[byte_cnt] = r.byte_in;
            byte_cnt++;
            res.ok = 1'b1;
          end
        end
        MODE_READ: begin
          res.ok = fetch_bits(r.count, v);
          if (res.ok) res.value = v;
        end
        // skip in chunks, consumed chunks stay consumed on failure
        MODE_SKIP: begin
          res.ok = 1'b1;
          done = 0;
          while (done < r.count) begin
            n = (r.count - done < SKIP_CHUNK) ? r.count - done : SKIP_CHUNK;
            if (!fetch_bits(n, v)) begin
              res.ok = 1'b0;
              break;
            end
            done += n;
          end
        end
        MODE_UE: begin
          res.ok = decode_ue(v);
          if (res.ok) res.value = v;
        end
        MODE_SE: begin
          res.ok = decode_se(v);
          if (res.ok) res.value = v;
        end
        // scaling list ends early once the next scale wraps to zero
        MODE_SCALING: begin
          res.ok = 1'b1;
          last = SL_START;
          next_scale = SL_START;
          for (j = 0; j < r.count && next_scale != 8'h00; j++) begin
            if (!decode_se(v)) begin
              res.ok = 1'b0;
              break;
            end
            next_scale = last + v[7:0];
            if (next_scale != 8'h00) last = next_scale;
          end
        end
        default: ;
      endcase
      return res;
    endfunction

    function void note_request(request_t r);
      awaited_results.push_back(execute_command(r));
    endfunction

    function void check_result(logic [31:0] value, logic ok);
      result_t exp_res;
      if (awaited_results.size() == 0) begin
        $error("result with no request waiting: value %h ok %0b", value, ok);
        errors++;
        return;
      end
      exp_res = awaited_results.pop_front();
      if (value !== exp_res.value) begin
        $error("value: expected %h actual %h", exp_res.value, value);
        errors++;
      end
      if (ok !== exp_res.ok) begin
        $error("ok: expected %0b actual %0b", exp_res.ok, ok);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return awaited_results.size();
    endfunction
  endclass

endpackage

[tb/sv/tb_top.sv]
// tb_top: bench for nal_bit_reader_exp_golomb, directed requests then encoded payload sessions
// drives restart, load and parse requests with random gaps and stalls, checks every result
// depends on nbr_pkg, tb_nbr_pkg and the rtl of the block
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import nbr_pkg::*;
  import tb_nbr_pkg::*;

  localparam int unsigned REQUEST_TARGET = 1500;
  localparam int unsigned CYCLE_LIMIT    = 3000000;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned DRAIN_CYCLES   = 200;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic [2:0]  mode      = MODE_RESTART;
  logic [7:0]  byte_in   = 8'h00;
  logic [11:0] count     = 12'd0;
  logic        out_stall = 1'b0;
  wire         in_stall;
  wire         out_valid;
  wire  [31:0] value;
  wire         ok;

  nal_reader_scoreboard sb = new();

  int unsigned cycles        = 0;
  int unsigned sent          = 0;
  bit          quiet_stretch = 1'b0;
  bit          hold_pending  = 1'b0;

  // session contents
  bit          stream [$];
  logic [7:0]  payload [$];
  request_t    plan [$];

  nal_bit_reader_exp_golomb #(.MAX_BYTES(STORE_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .byte_in(byte_in),
    .count(count),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .value(value),
    .ok(ok)
  );

  always #1 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(value, ok);
  end

  // result side: random stalls, one long hold-off on demand
  initial begin
    int unsigned k;
    while (rst) @(negedge clk);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        k = HOLD_CYCLES;
      end else begin
        k = quiet_stretch ? 0 : $urandom_range(0, 8);
      end
      if (k != 0) begin
        out_stall <= 1'b1;
        repeat (k) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  function automatic request_t make_request(logic [2:0] m, logic [7:0] b, logic [11:0] c);
    request_t r;
    r.mode = m;
    r.byte_in = b;
    r.count = c;
    return r;
  endfunction

  // bytes heavy in zeros and 0x03 so emulation prevention shows up in raw data
  function automatic logic [7:0] biased_byte();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0, 1, 2: b = 8'h00;
      3:       b = EP_BYTE;
      4:       b = 8'h01;
      default: b = 8'($urandom);
    endcase
    return b;
  endfunction

  function automatic request_t random_request();
    logic [2:0]  m;
    logic [11:0] c;
    case ($urandom_range(0, 15))
      0:       m = MODE_RESTART;
      1:       m = MODE_LOAD;
      2:       m = MODE_INVALID;
      default: m = 3'(int'(MODE_READ) + int'($urandom_range(0, 4)));
    endcase
    case ($urandom_range(0, 3))
      0: c = 12'($urandom_range(0, 40));
      1: c = 12'($urandom);
      2: c = 12'($urandom_range(0, 8));
      default: begin
        case ($urandom_range(0, 3))
          0:       c = 12'd0;
          1:       c = 12'(MAX_READ);
          2:       c = 12'(MAX_READ + 1);
          default: c = 12'hFFF;
        endcase
      end
    endcase
    return make_request(m, 8'($urandom), c);
  endfunction

  function automatic void put_bits(logic [31:0] v, int unsigned n);
    int unsigned i;
    for (i = n; i > 0; i--) stream.push_back(v[i - 1]);
  endfunction

  function automatic void put_random(int unsigned n);
    int unsigned c;
    while (n > 0) begin
      c = (n > 32) ? 32 : n;
      put_bits($urandom, c);
      n -= c;
    end
  endfunction

  // exp-golomb code of k: zeros, a one, then the low bits of k+1
  function automatic void put_ue(logic [31:0] k);
    longint unsigned x;
    int unsigned     zeros;
    x = longint'(k) + 1;
    zeros = 0;
    while ((x >> (zeros + 1)) != 0) zeros++;
    put_bits(32'd0, zeros);
    stream.push_back(1'b1);
    put_bits(x[31:0], zeros);
  endfunction

  function automatic logic [31:0] random_code();
    int unsigned zeros;
    logic [31:0] suffix;
    zeros = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 31) : $urandom_range(0, 6);
    suffix = $urandom & ((32'd1 << zeros) - 32'd1);
    return (32'd1 << zeros) - 32'd1 + suffix;
  endfunction

  // pack the bit stream into bytes, inserting 0x03 after two zeros before a byte below 4
  function automatic void pack_stream();
    int unsigned i;
    int unsigned j;
    int unsigned zrun;
    logic [7:0]  b;
    while (stream.size() % 8 != 0) stream.push_back(1'($urandom));
    zrun = 0;
    for (i = 0; i < stream.size(); i += 8) begin
      b = 8'h00;
      for (j = 0; j < 8; j++) b = {b[6:0], stream[i + j]};
      if (zrun >= 2 && b <= EP_BYTE) begin
        payload.push_back(EP_BYTE);
        zrun = 0;
      end
      payload.push_back(b);
      zrun = (b == 8'h00) ? zrun + 1 : 0;
    end
    while (payload.size() > STORE_DEPTH) void'(payload.pop_back());
  endfunction

  // well-formed session: encoded fields with matching parse requests
  function automatic void build_parsed_session();
    int unsigned nfields;
    int unsigned f;
    int unsigned sel;
    int unsigned n;
    int unsigned m;
    int unsigned j;
    int          delta;
    int          last;
    int          next_scale;
    logic [2:0]  m_code;
    logic [11:0] c;
    nfields = $urandom_range(3, 25);
    for (f = 0; f < nfields; f++) begin
      sel = $urandom_range(0, 99);
      c = 12'd0;
      if (sel < 25) begin
        if ($urandom_range(0, 3) == 0) n = ($urandom_range(0, 1) == 1) ? MAX_READ : 0;
        else n = $urandom_range(1, 31);
        put_random(n);
        m_code = MODE_READ;
        c = 12'(n);
      end else if (sel < 35) begin
        n = $urandom_range(0, 80);
        put_random(n);
        m_code = MODE_SKIP;
        c = 12'(n);
      end else if (sel < 60) begin
        put_ue(random_code());
        m_code = MODE_UE;
      end else if (sel < 80) begin
        put_ue(random_code());
        m_code = MODE_SE;
      end else if (sel < 97) begin
        // scaling list, sometimes closed early by a delta that wraps to zero
        m = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
        last = 8;
        for (j = 0; j < m; j++) begin
          if ($urandom_range(0, 9) == 0) delta = -last;
          else delta = int'($urandom_range(0, 40)) - 20;
          put_ue((delta > 0) ? 32'(2 * delta - 1) : 32'(-2 * delta));
          next_scale = (last + delta) & 255;
          if (next_scale == 0) break;
          last = next_scale;
        end
        m_code = MODE_SCALING;
        c = 12'(m);
      end else begin
        // prefix too long, everything after it is out of step
        put_bits(32'd0, 32);
        put_bits(32'd0, $urandom_range(0, 8));
        stream.push_back(1'b1);
        m_code = MODE_UE;
      end
      if ($urandom_range(0, 9) == 0) plan.push_back(random_request());
      else plan.push_back(make_request(m_code, 8'($urandom), c));
      if (sel >= 97) break;
    end
    if ($urandom_range(0, 1) == 0) put_bits(32'h80, 8);
    pack_stream();
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) if (payload.size() > 1) void'(payload.pop_back());
    end
    plan.push_back(make_request(MODE_READ, 8'($urandom), 12'($urandom_range(1, 32))));
  endfunction

  task automatic send_request(request_t r);
    int unsigned gap;
    gap = quiet_stretch ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    mode <= r.mode;
    byte_in <= r.byte_in;
    count <= r.count;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.outstanding() != 0);
  endtask

  task automatic run_session();
    int unsigned i;
    send_request(make_request(MODE_RESTART, 8'($urandom), 12'($urandom)));
    for (i = 0; i < payload.size(); i++)
      send_request(make_request(MODE_LOAD, payload[i], 12'($urandom)));
    for (i = 0; i < plan.size(); i++) send_request(plan[i]);
  endtask

  // directed: extremes, every mode, emulation prevention, long prefix, past the end
  task automatic run_directed();
    logic [7:0] seed_bytes [$];
    int unsigned i;
    seed_bytes = '{8'h00, 8'h00, EP_BYTE, 8'h01, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00,
                   EP_BYTE, 8'h80};
    send_request(make_request(MODE_RESTART, 8'h00, 12'd0));
    for (i = 0; i < seed_bytes.size(); i++)
      send_request(make_request(MODE_LOAD, seed_bytes[i], 12'd0));
    send_request(make_request(MODE_READ, 8'h00, 12'd0));
    send_request(make_request(MODE_READ, 8'h00, 12'(MAX_READ + 1)));
    send_request(make_request(MODE_READ, 8'hFF, 12'(MAX_READ)));
    send_request(make_request(MODE_SE, 8'h00, 12'd0));
    send_request(make_request(MODE_READ, 8'h00, 12'd8));
    send_request(make_request(MODE_UE, 8'h00, 12'd0));
    send_request(make_request(MODE_SKIP, 8'h00, 12'd0));
    send_request(make_request(MODE_SCALING, 8'h00, 12'd2));
    send_request(make_request(MODE_INVALID, 8'hFF, 12'hFFF));
    send_request(make_request(MODE_SKIP, 8'h00, 12'hFFF));
    send_request(make_request(MODE_READ, 8'h00, 12'hFFF));
    send_request(make_request(MODE_RESTART, 8'hFF, 12'hFFF));
  endtask

  initial begin
    int unsigned sess;
    int unsigned i;
    int unsigned sel;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    run_directed();

    sess = 0;
    while (sent < REQUEST_TARGET) begin
      quiet_stretch = ($urandom_range(0, 3) == 0);
      if (sess == 2) hold_pending = 1'b1;
      if (sess == 4 || sess % 9 == 8) drain_results();
      stream.delete();
      payload.delete();
      plan.delete();
      sel = $urandom_range(0, 11);
      if (sess == 1 || sel == 0) begin
        // fill the store, then two loads that must be refused
        for (i = 0; i < STORE_DEPTH; i++) payload.push_back(biased_byte());
        plan.push_back(make_request(MODE_LOAD, 8'($urandom), 12'($urandom)));
        plan.push_back(make_request(MODE_LOAD, 8'($urandom), 12'($urandom)));
        repeat ($urandom_range(3, 8)) plan.push_back(random_request());
      end else if (sel < 4) begin
        // raw noise
        repeat ($urandom_range(1, 40)) payload.push_back(biased_byte());
        repeat ($urandom_range(3, 15)) plan.push_back(random_request());
      end else begin
        build_parsed_session();
      end
      run_session();
      sess++;
    end

    quiet_stretch = 1'b0;
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
